// ===== hdl/frc_pkg.sv =====
// Shared types and constants of the framed room command parser.
// Used by frc_front, frc_queue, frc_back and framed_room_command_parser.
package frc_pkg;

   localparam int ROOM_COUNT  = 8;
   localparam int PAYLOAD_LEN = 5;
   localparam int QUEUE_DEPTH = 2;

   localparam int ROOM_IDX_W  = $clog2(ROOM_COUNT);
   localparam int KEPT_BYTES  = 4;
   localparam int KEEP_IDX_W  = $clog2(KEPT_BYTES);
   localparam int COUNT_W     = $clog2(PAYLOAD_LEN + 1);
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] HEAD_BYTE   = 8'h3C;
   localparam logic [7:0] TAIL_BYTE   = 8'h3E;
   localparam logic [7:0] CMD_ACFAN   = 8'h12;
   localparam logic [7:0] CMD_TEMP    = 8'h13;
   localparam logic [7:0] CMD_BOUND_A = 8'h20;
   localparam logic [7:0] CMD_BOUND_B = 8'h21;

   typedef enum logic [2:0] {
      PH_HUNT  = 3'd0,
      PH_HEAD2 = 3'd1,
      PH_BODY  = 3'd2,
      PH_TAIL1 = 3'd3,
      PH_TAIL2 = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      ACT_IGNORE  = 3'd0,
      ACT_ACFAN   = 3'd1,
      ACT_TEMP    = 3'd2,
      ACT_BOUND_A = 3'd3,
      ACT_BOUND_B = 3'd4
   } action_type;

   // One complete frame as handed from the parser to the executor
   typedef struct packed {
      logic [7:0] room;
      logic [7:0] cmd;
      logic [7:0] high;
      logic [7:0] low;
   } frame_type;

endpackage

// ===== hdl/frc_front.sv =====
// Frame parser: hunts head bytes, collects the payload, checks tail bytes.
// Depends on frc_pkg; pushes each complete frame toward frc_queue.
module frc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               byte_take,
   input  logic [7:0]         rx_byte,
   output logic               frame_push,
   output frc_pkg::frame_type frame_data
);

   frc_pkg::phase_type phase_ff, phase_in;
   logic [frc_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [7:0] payload_ff [frc_pkg::KEPT_BYTES];
   logic store_en;
   logic last_body;

   assign last_body = (count_ff == frc_pkg::COUNT_W'(frc_pkg::PAYLOAD_LEN - 1));

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (byte_take) begin
         unique case (phase_ff)
            frc_pkg::PH_HUNT: begin
               if (rx_byte == frc_pkg::HEAD_BYTE) phase_in = frc_pkg::PH_HEAD2;
            end
            frc_pkg::PH_HEAD2: begin
               phase_in = (rx_byte == frc_pkg::HEAD_BYTE) ? frc_pkg::PH_BODY
                                                           : frc_pkg::PH_HUNT;
            end
            frc_pkg::PH_BODY: begin
               if (last_body) phase_in = frc_pkg::PH_TAIL1;
            end
            frc_pkg::PH_TAIL1: begin
               phase_in = (rx_byte == frc_pkg::TAIL_BYTE) ? frc_pkg::PH_TAIL2
                                                           : frc_pkg::PH_HUNT;
            end
            frc_pkg::PH_TAIL2: phase_in = frc_pkg::PH_HUNT;
            default:           phase_in = frc_pkg::PH_HUNT;
         endcase
      end
   end

   // Outputs and payload counter
   always_comb begin
      count_in   = count_ff;
      store_en   = 1'b0;
      frame_push = 1'b0;
      if (byte_take) begin
         unique case (phase_ff)
            frc_pkg::PH_HEAD2: begin
               count_in = '0;
            end
            frc_pkg::PH_BODY: begin
               count_in = count_ff + 1'b1;
               store_en = (int'(count_ff) < frc_pkg::KEPT_BYTES);
            end
            frc_pkg::PH_TAIL2: begin
               frame_push = (rx_byte == frc_pkg::TAIL_BYTE);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= frc_pkg::PH_HUNT;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   // Payload bytes need no reset: every frame writes all kept bytes
   always_ff @(posedge clock) begin
      if (store_en) payload_ff[count_ff[frc_pkg::KEEP_IDX_W-1:0]] <= rx_byte;
   end

   assign frame_data.room = payload_ff[0];
   assign frame_data.cmd  = payload_ff[1];
   assign frame_data.high = payload_ff[2];
   assign frame_data.low  = payload_ff[3];

endmodule

// ===== hdl/frc_queue.sv =====
// Short frame queue between the parser and the executor.
// Depends on frc_pkg for the frame type and depth.
module frc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  frc_pkg::frame_type push_data,
   output logic               full,
   input  logic               pop,
   output frc_pkg::frame_type pop_data,
   output logic               empty
);

   frc_pkg::frame_type entry_ff [frc_pkg::QUEUE_DEPTH];
   logic [frc_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [frc_pkg::QCNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full     = (count_ff == frc_pkg::QCNT_W'(frc_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == frc_pkg::QPTR_W'(frc_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == frc_pkg::QPTR_W'(frc_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ===== hdl/frc_back.sv =====
// Frame executor: decodes a queued frame, updates the room tables and
// holds the result in the output register. Depends on frc_pkg.
module frc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               frame_avail,
   input  frc_pkg::frame_type frame,
   output logic               frame_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_action,
   output logic [7:0]         rsp_room_id,
   output logic [7:0]         rsp_value_high,
   output logic [7:0]         rsp_value_low,
   output logic [7:0]         rsp_room_temp,
   output logic [7:0]         rsp_room_ac,
   output logic [7:0]         rsp_room_fan
);

   logic [7:0] temp_ff [frc_pkg::ROOM_COUNT];
   logic [7:0] ac_ff   [frc_pkg::ROOM_COUNT];
   logic [7:0] fan_ff  [frc_pkg::ROOM_COUNT];

   logic valid_ff, valid_in;
   frc_pkg::action_type action_ff, action_in;
   logic [7:0] room_ff, high_ff, low_ff, temp_out_ff, ac_out_ff, fan_out_ff;
   logic [7:0] temp_out_in, ac_out_in, fan_out_in;

   logic room_ok;
   logic [frc_pkg::ROOM_IDX_W-1:0] idx;

   assign room_ok   = (frame.room != 8'd0) && (int'(frame.room) < frc_pkg::ROOM_COUNT);
   assign idx       = frame.room[frc_pkg::ROOM_IDX_W-1:0];
   assign frame_pop = frame_avail && (!valid_ff || rsp_ready);

   // Decode the frame at the head of the queue
   always_comb begin
      action_in = frc_pkg::ACT_IGNORE;
      if (room_ok) begin
         unique case (frame.cmd)
            frc_pkg::CMD_ACFAN:   action_in = frc_pkg::ACT_ACFAN;
            frc_pkg::CMD_TEMP:    action_in = frc_pkg::ACT_TEMP;
            frc_pkg::CMD_BOUND_A: action_in = frc_pkg::ACT_BOUND_A;
            frc_pkg::CMD_BOUND_B: action_in = frc_pkg::ACT_BOUND_B;
            default:              action_in = frc_pkg::ACT_IGNORE;
         endcase
      end
   end

   // Room state as seen after the update
   always_comb begin
      temp_out_in = temp_ff[idx];
      ac_out_in   = ac_ff[idx];
      fan_out_in  = fan_ff[idx];
      case (action_in)
         frc_pkg::ACT_IGNORE: begin
            temp_out_in = '0;
            ac_out_in   = '0;
            fan_out_in  = '0;
         end
         frc_pkg::ACT_ACFAN: begin
            ac_out_in  = frame.high;
            fan_out_in = frame.low;
         end
         frc_pkg::ACT_TEMP: temp_out_in = frame.high;
         default: ;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (frame_pop)           valid_in = 1'b1;
      else if (rsp_ready)      valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         for (int i = 0; i < frc_pkg::ROOM_COUNT; i++) begin
            temp_ff[i] <= '0;
            ac_ff[i]   <= '0;
            fan_ff[i]  <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         if (frame_pop && action_in == frc_pkg::ACT_ACFAN) begin
            ac_ff[idx]  <= frame.high;
            fan_ff[idx] <= frame.low;
         end
         if (frame_pop && action_in == frc_pkg::ACT_TEMP) begin
            temp_ff[idx] <= frame.high;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (frame_pop) begin
         action_ff   <= action_in;
         room_ff     <= frame.room;
         high_ff     <= frame.high;
         low_ff      <= frame.low;
         temp_out_ff <= temp_out_in;
         ac_out_ff   <= ac_out_in;
         fan_out_ff  <= fan_out_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_action     = action_ff;
   assign rsp_room_id    = room_ff;
   assign rsp_value_high = high_ff;
   assign rsp_value_low  = low_ff;
   assign rsp_room_temp  = temp_out_ff;
   assign rsp_room_ac    = ac_out_ff;
   assign rsp_room_fan   = fan_out_ff;

endmodule

// ===== hdl/framed_room_command_parser.sv =====
// Top level of the framed room command parser.
// Depends on frc_pkg, frc_front, frc_queue and frc_back.
//
// Usage:
//   req_ channel: one serial byte per request (req_rx_byte). A byte is
//   taken at every edge with req_valid and req_ready high.
//   rsp_ channel: one result per complete, well-formed frame
//   (0x3C 0x3C, five payload bytes, 0x3E 0x3E); malformed frames and
//   stray bytes give no result.
// Result path: the parser pushes the frame into the queue when the closing
//   tail byte is taken, then the executor pops it and registers the result.
// Throughput: one byte per cycle while req_ready is high. The parser, the
//   two-entry frame queue and the executor's output register stall in
//   turn; a frame needs at least nine bytes, so the queue only fills when
//   the receiver holds rsp_ready low for long.
// Stall: while the receiver holds rsp_ready low, the result holds in the
//   output register and finished frames wait in the queue; req_ready
//   drops only when the queue is full.
// Reset (synchronous, active high): the parser returns to hunting the
//   first head byte, the queue empties, the result register invalidates
//   and the temperature, AC and fan tables of every room clear to zero.
//   No clearing pass is needed; the block accepts bytes right after reset.
module framed_room_command_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_action,
   output logic [7:0] rsp_room_id,
   output logic [7:0] rsp_value_high,
   output logic [7:0] rsp_value_low,
   output logic [7:0] rsp_room_temp,
   output logic [7:0] rsp_room_ac,
   output logic [7:0] rsp_room_fan
);

   logic               byte_take;
   logic               frame_push;
   frc_pkg::frame_type push_frame;
   logic               queue_full;
   logic               queue_empty;
   logic               frame_pop;
   frc_pkg::frame_type head_frame;

   // Accept a byte whenever the queue can take a frame
   assign req_ready = !queue_full;
   assign byte_take = req_valid && req_ready;

   // Front: hunt, collect and check each frame
   frc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_take  (byte_take),
      .rx_byte    (req_rx_byte),
      .frame_push (frame_push),
      .frame_data (push_frame)
   );

   // Hold finished frames until the executor is free
   frc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (frame_push),
      .push_data (push_frame),
      .full      (queue_full),
      .pop       (frame_pop),
      .pop_data  (head_frame),
      .empty     (queue_empty)
   );

   // Back: decode, update room tables, drive the result register
   frc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .frame_avail    (!queue_empty),
      .frame          (head_frame),
      .frame_pop      (frame_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_action     (rsp_action),
      .rsp_room_id    (rsp_room_id),
      .rsp_value_high (rsp_value_high),
      .rsp_value_low  (rsp_value_low),
      .rsp_room_temp  (rsp_room_temp),
      .rsp_room_ac    (rsp_room_ac),
      .rsp_room_fan   (rsp_room_fan)
   );

endmodule
